@@ sv/sdde_pkg.sv @@
`timescale 1ns / 1ps

package sdde_pkg;

    localparam int BUS_COUNT_DEFAULT     = 2;
    localparam int ADDRESS_LIMIT_DEFAULT = 3;
    localparam int QUEUE_DEPTH           = 4;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
    localparam logic [7:0]  SYNC_BYTE     = 8'h05;
    localparam logic [7:0]  WRITE_FLAG    = 8'h80;
    localparam logic [7:0]  CRC_POLY      = 8'h07;

    // response byte positions
    localparam logic [2:0] RESP_SYNC_POS   = 3'd0;
    localparam logic [2:0] RESP_VALUE_POS  = 3'd3;
    localparam logic [2:0] RESP_CRC_POS    = 3'd7;

    // datagram beat positions
    localparam logic [2:0] BEAT_SYNC       = 3'd0;
    localparam logic [2:0] BEAT_ADDR       = 3'd1;
    localparam logic [2:0] BEAT_REG        = 3'd2;
    localparam logic [2:0] BEAT_DATA3      = 3'd3;
    localparam logic [2:0] BEAT_DATA2      = 3'd4;
    localparam logic [2:0] BEAT_DATA1      = 3'd5;
    localparam logic [2:0] BEAT_DATA0      = 3'd6;
    localparam logic [2:0] WRITE_LAST_BEAT = 3'd7;
    localparam logic [2:0] READ_LAST_BEAT  = 3'd3;

    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_RX_BYTE = 2'd2,
        OP_TICK    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_ARG  = 3'd1,
        ST_BAD_SYNC = 3'd2,
        ST_BAD_CRC  = 3'd3,
        ST_TIMEOUT  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_READ,
        JOB_STATUS
    } job_kind_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  bus_select;
        logic [7:0]  slave_address;
        logic [6:0]  register_index;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  tx_bus;
        logic [7:0]  tx_byte;
        logic        last;
        logic [31:0] read_value;
        logic [2:0]  status;
    } rsp_t;

    typedef struct packed {
        job_kind_t   jkind;
        logic [1:0]  bus;
        logic [7:0]  addr;
        logic [6:0]  reg_index;
        logic [31:0] data;
        status_t     status;
    } job_t;

    function automatic logic [7:0] crc_add(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7] ^ b[i])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ sv/sdde_queue.sv @@
`timescale 1ns / 1ps

module sdde_queue import sdde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

@@ sv/sdde_front.sv @@
`timescale 1ns / 1ps

module sdde_front import sdde_pkg::*;
#(
    parameter int BUS_COUNT     = BUS_COUNT_DEFAULT,
    parameter int ADDRESS_LIMIT = ADDRESS_LIMIT_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_t        cmd,
    input  logic        cfg_valid,
    input  logic [15:0] cfg_data,
    output logic        push,
    output job_t        push_job,
    input  logic        queue_full
);

    logic        accept;
    logic        clear;
    logic        bad_arg;
    logic [15:0] idle_inc;

    logic [15:0] timeout_reg;
    logic        pending_reg, pending_next;
    logic [2:0]  count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic        sync_reg, sync_next;
    logic [31:0] value_reg, value_next;
    logic [15:0] idle_reg, idle_next;

    assign cmd_stall = queue_full;
    assign accept    = cmd_valid && !queue_full;
    assign bad_arg   = ({1'b0, cmd.bus_select} >= 3'(BUS_COUNT))
                    || ({1'b0, cmd.slave_address} > 9'(ADDRESS_LIMIT));
    assign idle_inc  = (idle_reg < IDLE_MAX) ? idle_reg + 16'd1 : idle_reg;

    always_comb
    begin
        pending_next = pending_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        sync_next    = sync_reg;
        value_next   = value_reg;
        idle_next    = idle_reg;
        clear        = 1'b0;
        push         = 1'b0;

        push_job.jkind     = JOB_STATUS;
        push_job.bus       = cmd.bus_select;
        push_job.addr      = cmd.slave_address;
        push_job.reg_index = cmd.register_index;
        push_job.data      = cmd.write_data;
        push_job.status    = ST_OK;

        if (accept)
        begin
            case (cmd.opcode)
                OP_WRITE, OP_READ:
                begin
                    // a new command abandons any pending read
                    clear = 1'b1;
                    push  = 1'b1;
                    if (bad_arg)
                    begin
                        push_job.jkind  = JOB_STATUS;
                        push_job.status = ST_BAD_ARG;
                        push_job.data   = '0;
                    end
                    else if (cmd.opcode == OP_WRITE)
                        push_job.jkind = JOB_WRITE;
                    else
                        push_job.jkind = JOB_READ;
                end
                OP_TICK:
                begin
                    if (pending_reg)
                    begin
                        if (idle_inc >= timeout_reg)
                        begin
                            clear           = 1'b1;
                            push            = 1'b1;
                            push_job.status = ST_TIMEOUT;
                            push_job.data   = '0;
                        end
                        else
                            idle_next = idle_inc;
                    end
                end
                OP_RX_BYTE:
                begin
                    if (pending_reg)
                    begin
                        idle_next = '0;
                        if (count_reg != RESP_CRC_POS)
                        begin
                            if (count_reg == RESP_SYNC_POS)
                                sync_next = (cmd.rx_byte == SYNC_BYTE);
                            if (count_reg >= RESP_VALUE_POS)
                                value_next = {value_reg[23:0], cmd.rx_byte};
                            crc_next   = crc_add(crc_reg, cmd.rx_byte);
                            count_next = count_reg + 3'd1;
                        end
                        else
                        begin
                            clear = 1'b1;
                            push  = 1'b1;
                            if (!sync_reg)
                            begin
                                push_job.status = ST_BAD_SYNC;
                                push_job.data   = '0;
                            end
                            else if (crc_reg != cmd.rx_byte)
                            begin
                                push_job.status = ST_BAD_CRC;
                                push_job.data   = '0;
                            end
                            else
                            begin
                                push_job.status = ST_OK;
                                push_job.data   = value_reg;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (clear)
        begin
            pending_next = 1'b0;
            count_next   = '0;
            crc_next     = '0;
            sync_next    = 1'b0;
            value_next   = '0;
            idle_next    = '0;
        end
        // a good read request leaves a read pending
        if (push && push_job.jkind == JOB_READ)
            pending_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            pending_reg <= 1'b0;
            count_reg   <= '0;
            crc_reg     <= '0;
            sync_reg    <= 1'b0;
            value_reg   <= '0;
            idle_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
                timeout_reg <= cfg_data;
            pending_reg <= pending_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            sync_reg    <= sync_next;
            value_reg   <= value_next;
            idle_reg    <= idle_next;
        end
    end

endmodule

@@ sv/sdde_back.sv @@
`timescale 1ns / 1ps

module sdde_back import sdde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic queue_empty,
    input  job_t head,
    output logic pop,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic       busy_reg, busy_next;
    job_t       job_reg, job_next;
    logic [2:0] beat_reg, beat_next;
    logic [7:0] crc_reg, crc_next;
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_t       rsp_reg, rsp_next;

    job_t       cur_job;
    logic [2:0] beat;
    logic [7:0] crc_cur;
    logic       out_free;
    logic       emit;
    rsp_t       beat_rsp;

    assign cur_job  = busy_reg ? job_reg : head;
    assign beat     = busy_reg ? beat_reg : BEAT_SYNC;
    assign crc_cur  = busy_reg ? crc_reg : 8'd0;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign emit     = out_free && (busy_reg || !queue_empty);
    assign pop      = emit && !busy_reg;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // form the beat for the current position of the current job
    always_comb
    begin
        beat_rsp.kind       = KIND_TX;
        beat_rsp.tx_bus     = cur_job.bus;
        beat_rsp.tx_byte    = '0;
        beat_rsp.last       = 1'b0;
        beat_rsp.read_value = '0;
        beat_rsp.status     = ST_OK;
        case (cur_job.jkind)
            JOB_WRITE:
            begin
                case (beat)
                    BEAT_SYNC:  beat_rsp.tx_byte = SYNC_BYTE;
                    BEAT_ADDR:  beat_rsp.tx_byte = cur_job.addr;
                    BEAT_REG:   beat_rsp.tx_byte = WRITE_FLAG | {1'b0, cur_job.reg_index};
                    BEAT_DATA3: beat_rsp.tx_byte = cur_job.data[31:24];
                    BEAT_DATA2: beat_rsp.tx_byte = cur_job.data[23:16];
                    BEAT_DATA1: beat_rsp.tx_byte = cur_job.data[15:8];
                    BEAT_DATA0: beat_rsp.tx_byte = cur_job.data[7:0];
                    default:    beat_rsp.tx_byte = crc_cur;
                endcase
                beat_rsp.last = (beat == WRITE_LAST_BEAT);
            end
            JOB_READ:
            begin
                case (beat)
                    BEAT_SYNC: beat_rsp.tx_byte = SYNC_BYTE;
                    BEAT_ADDR: beat_rsp.tx_byte = cur_job.addr;
                    BEAT_REG:  beat_rsp.tx_byte = {1'b0, cur_job.reg_index};
                    default:   beat_rsp.tx_byte = crc_cur;
                endcase
                beat_rsp.last = (beat == READ_LAST_BEAT);
            end
            default:
            begin
                beat_rsp.kind       = KIND_STATUS;
                beat_rsp.tx_bus     = '0;
                beat_rsp.last       = 1'b1;
                beat_rsp.read_value = cur_job.data;
                beat_rsp.status     = cur_job.status;
            end
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        job_next       = job_reg;
        beat_next      = beat_reg;
        crc_next       = crc_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = beat_rsp;
            if (beat_rsp.last)
                busy_next = 1'b0;
            else
            begin
                busy_next = 1'b1;
                job_next  = cur_job;
                beat_next = beat + 3'd1;
                crc_next  = crc_add(crc_cur, beat_rsp.tx_byte);
            end
        end
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            beat_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            beat_reg      <= beat_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        crc_reg <= crc_next;
        rsp_reg <= rsp_next;
    end

endmodule

@@ sv/stepper_driver_uart_datagram_engine.sv @@
`timescale 1ns / 1ps

// Register datagram engine for a single-wire driver bus. The front classifies each
// accepted command, tracks a pending read (response bytes, CRC, tick timeout) and
// queues a job into a four-entry queue. The back turns each job into result beats
// at one beat per cycle unless rsp_stall holds it: a write gives 8 beats, a read
// request 4 and a status 1, and a single output beat register holds each beat.
// The input stalls only while the queue is full. The byte timeout in ticks is
// written through the cfg channel, which is always ready.

module stepper_driver_uart_datagram_engine import sdde_pkg::*;
#(
    parameter int BUS_COUNT     = BUS_COUNT_DEFAULT,
    parameter int ADDRESS_LIMIT = ADDRESS_LIMIT_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_t        cmd,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic push;
    job_t push_job;
    logic queue_full;
    logic queue_empty;
    logic pop;
    job_t head;

    assign cfg_ready = 1'b1;

    sdde_front #(
        .BUS_COUNT     (BUS_COUNT),
        .ADDRESS_LIMIT (ADDRESS_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    sdde_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    sdde_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

endmodule

@@ sv/sdde_checker.sv @@
`timescale 1ns / 1ps

module sdde_checker import sdde_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result beat changed");

    // a datagram streams without gaps once started
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && !rsp.last |=> rsp_valid)
        else $error("gap inside a datagram");

    // after a final beat the next beat opens a datagram or is a status
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && rsp.last |=>
            !rsp_valid || rsp.kind == KIND_STATUS || rsp.tx_byte == SYNC_BYTE)
        else $error("datagram does not start with sync");

    // a status beat stands alone and carries a known code
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind == KIND_STATUS |->
            rsp.last && rsp.tx_byte == 8'd0 && rsp.tx_bus == 2'd0 && rsp.status <= ST_TIMEOUT)
        else $error("malformed status beat");

endmodule

bind stepper_driver_uart_datagram_engine sdde_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

@@ tb/uart_datagram_checker.sv @@
`timescale 1ns / 1ps

module uart_datagram_checker import sdde_pkg::*;
#(
    parameter int BUS_COUNT     = BUS_COUNT_DEFAULT,
    parameter int ADDRESS_LIMIT = ADDRESS_LIMIT_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_stall,
    input  cmd_t        cmd,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_t        rsp,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          backlog
);

    localparam int REPORT_LIMIT = 10;

    logic [15:0] timeout_limit;
    logic        reply_open;
    logic [2:0]  reply_count;
    logic [7:0]  reply_crc;
    logic        reply_sync_ok;
    logic [31:0] reply_value;
    logic [15:0] reply_ticks;
    rsp_t        expected_beats [$];
    int          mismatch_total;

    // serial CRC-8, data bits taken LSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic fb;
        for (int k = 0; k < 8; k++)
        begin
            fb  = acc[7] ^ data[k];
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    task automatic drop_reply();
        reply_open    = 1'b0;
        reply_count   = '0;
        reply_crc     = '0;
        reply_sync_ok = 1'b0;
        reply_value   = '0;
        reply_ticks   = '0;
    endtask

    task automatic push_status(input status_t st, input logic [31:0] value);
        rsp_t r;
        r            = '0;
        r.kind       = KIND_STATUS;
        r.last       = 1'b1;
        r.read_value = value;
        r.status     = st;
        expected_beats.push_back(r);
    endtask

    task automatic predict_results(input cmd_t c);
        logic [7:0] frame [0:7];
        logic [7:0] acc;
        rsp_t       r;
        int         n;
        case (c.opcode)
            OP_WRITE, OP_READ:
            begin
                // a write or read command abandons a pending read silently
                drop_reply();
                if (c.bus_select >= BUS_COUNT || c.slave_address > ADDRESS_LIMIT)
                    push_status(ST_BAD_ARG, '0);
                else
                begin
                    frame[0] = SYNC_BYTE;
                    frame[1] = c.slave_address;
                    if (c.opcode == OP_WRITE)
                    begin
                        frame[2] = {1'b0, c.register_index} | WRITE_FLAG;
                        frame[3] = c.write_data[31:24];
                        frame[4] = c.write_data[23:16];
                        frame[5] = c.write_data[15:8];
                        frame[6] = c.write_data[7:0];
                        n = 8;
                    end
                    else
                    begin
                        frame[2] = {1'b0, c.register_index};
                        n = 4;
                    end
                    acc = '0;
                    for (int i = 0; i < n - 1; i++)
                        acc = crc8_step(acc, frame[i]);
                    frame[n - 1] = acc;
                    for (int i = 0; i < n; i++)
                    begin
                        r         = '0;
                        r.kind    = KIND_TX;
                        r.tx_bus  = c.bus_select;
                        r.tx_byte = frame[i];
                        r.last    = (i == n - 1);
                        expected_beats.push_back(r);
                    end
                    if (c.opcode == OP_READ)
                        reply_open = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (reply_open)
                begin
                    if (reply_ticks != IDLE_MAX)
                        reply_ticks++;
                    if (reply_ticks >= timeout_limit)
                    begin
                        drop_reply();
                        push_status(ST_TIMEOUT, '0);
                    end
                end
            end
            default:
            begin
                if (reply_open)
                begin
                    reply_ticks = '0;
                    if (reply_count < RESP_CRC_POS)
                    begin
                        if (reply_count == RESP_SYNC_POS)
                            reply_sync_ok = (c.rx_byte == SYNC_BYTE);
                        if (reply_count >= RESP_VALUE_POS)
                            reply_value = {reply_value[23:0], c.rx_byte};
                        reply_crc = crc8_step(reply_crc, c.rx_byte);
                        reply_count++;
                    end
                    else if (!reply_sync_ok)
                    begin
                        drop_reply();
                        push_status(ST_BAD_SYNC, '0);
                    end
                    else if (reply_crc != c.rx_byte)
                    begin
                        drop_reply();
                        push_status(ST_BAD_CRC, '0);
                    end
                    else
                    begin
                        r.read_value = reply_value;
                        drop_reply();
                        push_status(ST_OK, r.read_value);
                    end
                end
            end
        endcase
    endtask

    task automatic check_beat(input rsp_t got);
        rsp_t want;
        if (expected_beats.size() == 0)
        begin
            mismatch_total++;
            if (mismatch_total <= REPORT_LIMIT)
                $display("%0t: unexpected beat kind=%0d bus=%0d byte=%02h last=%0d value=%08h st=%0d",
                         $time, got.kind, got.tx_bus, got.tx_byte, got.last, got.read_value,
                         got.status);
        end
        else
        begin
            want = expected_beats.pop_front();
            if (got.kind !== want.kind || got.tx_bus !== want.tx_bus
                || got.tx_byte !== want.tx_byte || got.last !== want.last
                || got.read_value !== want.read_value || got.status !== want.status)
            begin
                mismatch_total++;
                if (mismatch_total <= REPORT_LIMIT)
                begin
                    $display("%0t: want kind=%0d bus=%0d byte=%02h last=%0d value=%08h st=%0d",
                             $time, want.kind, want.tx_bus, want.tx_byte, want.last,
                             want.read_value, want.status);
                    $display("%0t: got  kind=%0d bus=%0d byte=%02h last=%0d value=%08h st=%0d",
                             $time, got.kind, got.tx_bus, got.tx_byte, got.last,
                             got.read_value, got.status);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_limit = TIMEOUT_RESET;
            drop_reply();
            expected_beats.delete();
            mismatch_total = 0;
            mismatches <= 0;
            backlog    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                timeout_limit = cfg_data;
            // a result never leaves in the cycle its command enters, so compare first
            if (rsp_valid && !rsp_stall)
                check_beat(rsp);
            if (cmd_valid && !cmd_stall)
                predict_results(cmd);
            mismatches <= mismatch_total;
            backlog    <= expected_beats.size();
        end
    end

endmodule

@@ tb/tb_stepper_driver_uart_datagram_engine.sv @@
`timescale 1ns / 1ps

module tb_stepper_driver_uart_datagram_engine;
    import sdde_pkg::*;

    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;

    typedef enum int {
        REPLY_GOOD,
        REPLY_BAD_SYNC,
        REPLY_BAD_CRC,
        REPLY_BAD_BOTH,
        REPLY_CUT_SHORT,
        REPLY_SILENT
    } reply_shape_t;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    cmd_t        cmd;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    int          mismatches;
    int          backlog;

    bit          tail_phase;
    bit          hold_rsp;
    int          items_sent;
    int          quiet_cycles;
    logic [15:0] timeout_setting;

    stepper_driver_uart_datagram_engine
    #(
        .BUS_COUNT     (BUS_COUNT_DEFAULT),
        .ADDRESS_LIMIT (ADDRESS_LIMIT_DEFAULT)
    )
    dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    uart_datagram_checker
    #(
        .BUS_COUNT     (BUS_COUNT_DEFAULT),
        .ADDRESS_LIMIT (ADDRESS_LIMIT_DEFAULT)
    )
    checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cmd_t random_item(input opcode_t op);
        cmd_t c;
        c.opcode         = op;
        c.bus_select     = 2'($urandom_range(0, 3));
        c.slave_address  = 8'($urandom_range(0, 255));
        c.register_index = 7'($urandom_range(0, 127));
        c.write_data     = $urandom;
        c.rx_byte        = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic cmd_t command(input opcode_t op, input logic [1:0] bus,
                                     input logic [7:0] addr);
        cmd_t c;
        c               = random_item(op);
        c.bus_select    = bus;
        c.slave_address = addr;
        return c;
    endfunction

    function automatic logic [1:0] good_bus();
        return 2'($urandom_range(0, BUS_COUNT_DEFAULT - 1));
    endfunction

    function automatic logic [7:0] good_addr();
        return 8'($urandom_range(0, ADDRESS_LIMIT_DEFAULT));
    endfunction

    task automatic offer(input cmd_t c, input bit counted);
        if (!tail_phase && $urandom_range(0, 4) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (cmd_stall);
        if (counted)
            items_sent++;
    endtask

    task automatic settle();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (backlog != 0);
        // received bytes and ticks may still be in flight with no beat to show for it
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        settle();
        cfg_data  <= ticks;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        timeout_setting = ticks;
    endtask

    task automatic read_exchange(input logic [1:0] bus, input logic [7:0] addr,
                                 input reply_shape_t shape);
        logic [7:0] reply [0:7];
        logic [7:0] acc;
        cmd_t       c;
        int         stop_at;
        offer(command(OP_READ, bus, addr), 1);
        if (shape == REPLY_SILENT && timeout_setting <= 16'd12)
        begin
            repeat (timeout_setting) offer(random_item(OP_TICK), 1);
        end
        else
        begin
            for (int i = 0; i < 8; i++)
                reply[i] = 8'($urandom_range(0, 255));
            reply[0] = SYNC_BYTE;
            if (shape == REPLY_BAD_SYNC || shape == REPLY_BAD_BOTH)
            begin
                reply[0] = 8'($urandom_range(0, 255));
                if (reply[0] == SYNC_BYTE)
                    reply[0] = ~SYNC_BYTE;
            end
            acc = '0;
            for (int i = 0; i < 7; i++)
                for (int k = 0; k < 8; k++)
                    acc = {acc[6:0], 1'b0} ^ ((acc[7] ^ reply[i][k]) ? CRC_POLY : 8'h00);
            reply[7] = acc;
            if (shape == REPLY_BAD_CRC || shape == REPLY_BAD_BOTH)
                reply[7] = acc ^ 8'($urandom_range(1, 255));
            stop_at = (shape == REPLY_CUT_SHORT) ? $urandom_range(0, 7) : 8;
            for (int i = 0; i < stop_at; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) offer(random_item(OP_TICK), 1);
                c         = random_item(OP_RX_BYTE);
                c.rx_byte = reply[i];
                offer(c, 1);
            end
        end
    endtask

    task automatic random_traffic(input int upto);
        int           pick;
        int           flavor;
        reply_shape_t shape;
        while (items_sent < upto)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                offer(command(OP_WRITE, good_bus(), good_addr()), 1);
            else if (pick < 80)
            begin
                flavor = $urandom_range(0, 9);
                if (flavor < 5)
                    shape = REPLY_GOOD;
                else if (flavor == 5)
                    shape = REPLY_BAD_SYNC;
                else if (flavor == 6)
                    shape = REPLY_BAD_CRC;
                else if (flavor == 7)
                    shape = REPLY_BAD_BOTH;
                else if (flavor == 8)
                    shape = REPLY_CUT_SHORT;
                else
                    shape = REPLY_SILENT;
                read_exchange(good_bus(), good_addr(), shape);
            end
            else if (pick < 85)
                offer(random_item(OP_RX_BYTE), 0);
            else if (pick < 90)
                offer(random_item(OP_TICK), 0);
            else if (pick < 95)
                offer(random_item(OP_WRITE), 1);
            else
                offer(random_item(OP_READ), 1);
        end
    endtask

    // response side: random stall bursts, plus one long hold-off on request
    initial
    begin
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
                hold_rsp = 1'b0;
            end
            else if (!tail_phase && $urandom_range(0, 5) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        cmd_t c;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        tail_phase      = 1'b0;
        hold_rsp        = 1'b0;
        items_sent      = 0;
        timeout_setting = TIMEOUT_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes, bad arguments, idle drops, one clean read
        c = command(OP_WRITE, 2'd0, 8'd0);
        c.register_index = '0;
        c.write_data     = '0;
        offer(c, 1);
        c = command(OP_WRITE, 2'd1, 8'd3);
        c.register_index = 7'h7F;
        c.write_data     = 32'hFFFF_FFFF;
        offer(c, 1);
        offer(command(OP_WRITE, 2'd2, 8'd1), 1);
        offer(command(OP_READ, 2'd3, 8'd0), 1);
        offer(command(OP_WRITE, 2'd0, 8'd4), 1);
        offer(command(OP_READ, 2'd1, 8'd255), 1);
        offer(random_item(OP_RX_BYTE), 0);
        offer(random_item(OP_TICK), 0);
        read_exchange(2'd1, 8'd2, REPLY_GOOD);

        // shortest timeout: first tick fails the read; abandon with a bad command
        set_timeout(16'd1);
        read_exchange(2'd0, 8'd1, REPLY_SILENT);
        read_exchange(2'd1, 8'd2, REPLY_CUT_SHORT);
        offer(command(OP_WRITE, 2'd3, 8'd200), 1);

        set_timeout(16'($urandom_range(2, 12)));
        // hold the result side off while writes pile up behind it
        hold_rsp = 1'b1;
        repeat (10) offer(command(OP_WRITE, good_bus(), good_addr()), 1);
        random_traffic(160);

        set_timeout(16'hFFFF);
        random_traffic(290);

        set_timeout(16'($urandom_range(13, 400)));
        random_traffic(340);
        tail_phase = 1'b1;
        random_traffic(420);

        settle();
        if (mismatches == 0 && backlog == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ stepper_driver_uart_datagram_engine.f @@
sv/sdde_pkg.sv
sv/sdde_queue.sv
sv/sdde_front.sv
sv/sdde_back.sv
sv/stepper_driver_uart_datagram_engine.sv
sv/sdde_checker.sv
tb/uart_datagram_checker.sv
tb/tb_stepper_driver_uart_datagram_engine.sv
